// ===== hdl/arpc_pkg.sv =====
package arpc_pkg;

    typedef enum logic [3:0] {
        PH_VERSION  = 4'd0,
        PH_ID       = 4'd1,
        PH_SALT     = 4'd2,
        PH_SYMLEN   = 4'd3,
        PH_SYMBOL   = 4'd4,
        PH_NAMELEN  = 4'd5,
        PH_NAME     = 4'd6,
        PH_DECIMALS = 4'd7,
        PH_CAP      = 4'd8,
        PH_ISSUER   = 4'd9,
        PH_CUSTLEN  = 4'd10,
        PH_CUSTODY  = 4'd11,
        PH_EXCESS   = 4'd12
    } t_phase;

    localparam int unsigned CFG_ADDR_W = 2;

    localparam logic [CFG_ADDR_W-1:0] CFG_SYMBOL_LIMIT  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_NAME_LIMIT    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_CUSTODY_LIMIT = 2'd2;

    localparam logic [7:0] LIMIT_RESET     = 8'd255;
    localparam logic [7:0] VERSION_LAST    = 8'd1;
    localparam logic [7:0] HASH_LAST       = 8'd31;
    localparam logic [7:0] CAP_LAST        = 8'd15;
    localparam logic [7:0] DECIMALS_MAX    = 8'd38;
    localparam logic [7:0] ASCII_MAX       = 8'h7f;
    localparam logic [7:0] EXCESS_OFF_MAX  = 8'd254;
    localparam logic [7:0] ISSUER_SELF     = 8'd1;
    localparam logic [7:0] ISSUER_CUSTODY  = 8'd2;

    localparam logic [7:0] UTF8_LEAD2_MIN  = 8'hc2;
    localparam logic [7:0] UTF8_LEAD2_MAX  = 8'hdf;
    localparam logic [7:0] UTF8_LEAD3_MIN  = 8'he0;
    localparam logic [7:0] UTF8_LEAD3_MAX  = 8'hef;
    localparam logic [7:0] UTF8_LEAD4_MIN  = 8'hf0;
    localparam logic [7:0] UTF8_LEAD4_MAX  = 8'hf4;

    localparam logic [20:0] UTF8_MIN_2     = 21'h80;
    localparam logic [20:0] UTF8_MIN_3     = 21'h800;
    localparam logic [20:0] UTF8_MIN_4     = 21'h10000;
    localparam logic [20:0] UTF8_MAX       = 21'h10ffff;
    localparam logic [20:0] UTF8_SURR_LO   = 21'hd800;
    localparam logic [20:0] UTF8_SURR_HI   = 21'hdfff;

    typedef struct packed {
        logic [1:0]  pending;
        logic [20:0] code;
        logic [1:0]  min_class;
    } t_utf8_state;

    typedef struct packed {
        t_utf8_state state;
        logic        err;
    } t_utf8_result;

endpackage

// ===== hdl/arpc_in_if.sv =====
interface arpc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_message;

    modport source (output valid, output data_byte, output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

// ===== hdl/arpc_out_if.sv =====
interface arpc_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] field_tag;
    logic [7:0] echo_byte;
    logic [7:0] field_offset;
    logic       message_done;
    logic       failed;
    logic       accepted;

    modport source (
        output valid, output field_tag, output echo_byte, output field_offset,
        output message_done, output failed, output accepted, input ready
    );
    modport sink (
        input valid, input field_tag, input echo_byte, input field_offset,
        input message_done, input failed, input accepted, output ready
    );
endinterface

// ===== hdl/arpc_cfg_if.sv =====
interface arpc_cfg_if;
    import arpc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [7:0]            wdata;

    modport source (output valid, output addr, output wdata, input ready);
    modport sink   (input valid, input addr, input wdata, output ready);
endinterface

// ===== hdl/arpc_utf8.sv =====
module arpc_utf8
    import arpc_pkg::*;
(
    input  t_utf8_state  i_state,
    input  logic [7:0]   i_byte,
    input  logic         i_name_end,
    output t_utf8_result o_result
);

    t_utf8_state n_state;
    logic        n_err;
    logic [20:0] n_code;
    logic [20:0] min_code;

    assign n_code = {i_state.code[14:0], i_byte[5:0]};

    always_comb begin
        unique case (i_state.min_class)
            2'd3:    min_code = UTF8_MIN_4;
            2'd2:    min_code = UTF8_MIN_3;
            default: min_code = UTF8_MIN_2;
        endcase
    end

    always_comb begin
        n_state = i_state;
        n_err   = 1'b0;
        if (i_state.pending == 2'd0) begin
            if (i_byte <= ASCII_MAX) begin
                n_state = i_state;
            end else if (i_byte >= UTF8_LEAD2_MIN && i_byte <= UTF8_LEAD2_MAX) begin
                n_state.code      = {16'd0, i_byte[4:0]};
                n_state.pending   = 2'd1;
                n_state.min_class = 2'd1;
            end else if (i_byte >= UTF8_LEAD3_MIN && i_byte <= UTF8_LEAD3_MAX) begin
                n_state.code      = {17'd0, i_byte[3:0]};
                n_state.pending   = 2'd2;
                n_state.min_class = 2'd2;
            end else if (i_byte >= UTF8_LEAD4_MIN && i_byte <= UTF8_LEAD4_MAX) begin
                n_state.code      = {18'd0, i_byte[2:0]};
                n_state.pending   = 2'd3;
                n_state.min_class = 2'd3;
            end else begin
                n_err = 1'b1;
            end
        end else if (i_byte[7:6] != 2'b10) begin
            n_err           = 1'b1;
            n_state.pending = 2'd0;
        end else begin
            n_state.code    = n_code;
            n_state.pending = i_state.pending - 2'd1;
            if (i_state.pending == 2'd1) begin
                if (n_code < min_code || n_code > UTF8_MAX
                    || (n_code >= UTF8_SURR_LO && n_code <= UTF8_SURR_HI)) begin
                    n_err = 1'b1;
                end
            end
        end
        // A sequence still open on the last name byte is cut off.
        if (i_name_end && n_state.pending != 2'd0) begin
            n_err           = 1'b1;
            n_state.pending = 2'd0;
        end
    end

    assign o_result.state = n_state;
    assign o_result.err   = n_err;

endmodule

// ===== hdl/asset_register_payload_checker.sv =====
// A result is valid in the cycle after its request is accepted. One byte is
// taken per cycle unless stalled; each byte passes through one combinational
// state update between the input handshake and the result register. Reset
// (synchronous, active low) returns the parser to the version field, clears
// the failure flag and sets all three length limits to 255.
module asset_register_payload_checker
    import arpc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    arpc_cfg_if.sink   i_cfg,
    arpc_in_if.sink    i_in,
    arpc_out_if.source o_out
);

    logic [7:0]  r_symbol_limit;
    logic [7:0]  r_name_limit;
    logic [7:0]  r_custody_limit;

    t_phase      r_phase,        n_phase;
    logic [7:0]  r_offset,       n_offset;
    logic [7:0]  r_field_length, n_field_length;
    logic [1:0]  r_issuer,       n_issuer;
    t_utf8_state r_utf8,         n_utf8;
    logic        r_error_seen,   n_error_seen;

    logic        r_out_valid;
    logic [3:0]  r_tag;
    logic [7:0]  r_echo;
    logic [7:0]  r_off_out;
    logic        r_done;
    logic        r_failed;
    logic        r_accepted;

    logic         in_acc;
    logic         cfg_acc;
    logic [7:0]   b;
    logic         last;
    logic [7:0]   len_last;
    logic         ok;
    t_utf8_result utf8_res;

    assign b        = i_in.data_byte;
    assign last     = i_in.end_of_message;
    assign len_last = r_field_length - 8'd1;

    assign i_cfg.ready = 1'b1;
    assign cfg_acc     = i_cfg.valid & i_cfg.ready;
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_acc      = i_in.valid & i_in.ready;

    arpc_utf8 u_utf8 (
        .i_state    (r_utf8),
        .i_byte     (b),
        .i_name_end (r_offset == len_last),
        .o_result   (utf8_res)
    );

    always_comb begin
        n_phase        = r_phase;
        n_offset       = r_offset + 8'd1;
        n_field_length = r_field_length;
        n_issuer       = r_issuer;
        n_utf8         = r_utf8;
        n_error_seen   = r_error_seen;
        unique case (r_phase)
            PH_VERSION: begin
                if (b != r_offset) n_error_seen = 1'b1;
                if (r_offset == VERSION_LAST) begin
                    n_phase  = PH_ID;
                    n_offset = 8'd0;
                end
            end
            PH_ID: begin
                if (r_offset == HASH_LAST) begin
                    n_phase  = PH_SALT;
                    n_offset = 8'd0;
                end
            end
            PH_SALT: begin
                if (r_offset == HASH_LAST) begin
                    n_phase  = PH_SYMLEN;
                    n_offset = 8'd0;
                end
            end
            PH_SYMLEN: begin
                if (b == 8'd0 || b > r_symbol_limit) n_error_seen = 1'b1;
                n_field_length = b;
                n_offset       = 8'd0;
                n_phase        = (b == 8'd0) ? PH_NAMELEN : PH_SYMBOL;
            end
            PH_SYMBOL: begin
                if (b > ASCII_MAX) n_error_seen = 1'b1;
                if (r_offset == len_last) begin
                    n_phase  = PH_NAMELEN;
                    n_offset = 8'd0;
                end
            end
            PH_NAMELEN: begin
                if (b == 8'd0 || b > r_name_limit) n_error_seen = 1'b1;
                n_field_length = b;
                n_utf8         = '0;
                n_offset       = 8'd0;
                n_phase        = (b == 8'd0) ? PH_DECIMALS : PH_NAME;
            end
            PH_NAME: begin
                n_utf8 = utf8_res.state;
                if (utf8_res.err) n_error_seen = 1'b1;
                if (r_offset == len_last) begin
                    n_phase  = PH_DECIMALS;
                    n_offset = 8'd0;
                end
            end
            PH_DECIMALS: begin
                if (b > DECIMALS_MAX) n_error_seen = 1'b1;
                n_phase  = PH_CAP;
                n_offset = 8'd0;
            end
            PH_CAP: begin
                if (r_offset == CAP_LAST) begin
                    n_phase  = PH_ISSUER;
                    n_offset = 8'd0;
                end
            end
            PH_ISSUER: begin
                if (b == ISSUER_SELF || b == ISSUER_CUSTODY) begin
                    n_issuer = b[1:0];
                end else begin
                    n_issuer     = 2'd0;
                    n_error_seen = 1'b1;
                end
                n_phase  = PH_CUSTLEN;
                n_offset = 8'd0;
            end
            PH_CUSTLEN: begin
                if (b > r_custody_limit || (r_issuer == ISSUER_SELF[1:0] && b != 8'd0)) begin
                    n_error_seen = 1'b1;
                end
                n_field_length = b;
                n_offset       = 8'd0;
                n_phase        = (b == 8'd0) ? PH_EXCESS : PH_CUSTODY;
            end
            PH_CUSTODY: begin
                if (r_offset == len_last) begin
                    n_phase  = PH_EXCESS;
                    n_offset = 8'd0;
                end
            end
            default: begin
                n_error_seen = 1'b1;
                n_offset     = (r_offset < EXCESS_OFF_MAX) ? r_offset + 8'd1 : r_offset;
            end
        endcase
    end

    assign ok = last && !n_error_seen && n_phase == PH_EXCESS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_symbol_limit  <= LIMIT_RESET;
            r_name_limit    <= LIMIT_RESET;
            r_custody_limit <= LIMIT_RESET;
        end else if (cfg_acc) begin
            unique case (i_cfg.addr)
                CFG_SYMBOL_LIMIT:  r_symbol_limit  <= i_cfg.wdata;
                CFG_NAME_LIMIT:    r_name_limit    <= i_cfg.wdata;
                CFG_CUSTODY_LIMIT: r_custody_limit <= i_cfg.wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_VERSION;
            r_offset       <= 8'd0;
            r_field_length <= 8'd0;
            r_issuer       <= 2'd0;
            r_utf8         <= '0;
            r_error_seen   <= 1'b0;
        end else if (in_acc) begin
            if (last) begin
                r_phase        <= PH_VERSION;
                r_offset       <= 8'd0;
                r_field_length <= 8'd0;
                r_issuer       <= 2'd0;
                r_utf8         <= '0;
                r_error_seen   <= 1'b0;
            end else begin
                r_phase        <= n_phase;
                r_offset       <= n_offset;
                r_field_length <= n_field_length;
                r_issuer       <= n_issuer;
                r_utf8         <= n_utf8;
                r_error_seen   <= n_error_seen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_tag      <= r_phase;
            r_echo     <= b;
            r_off_out  <= r_offset;
            r_done     <= last;
            r_failed   <= n_error_seen || (last && !ok);
            r_accepted <= ok;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.field_tag    = r_tag;
    assign o_out.echo_byte    = r_echo;
    assign o_out.field_offset = r_off_out;
    assign o_out.message_done = r_done;
    assign o_out.failed       = r_failed;
    assign o_out.accepted     = r_accepted;

    a_accept_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.accepted |-> o_out.message_done && !o_out.failed)
        else $error("accepted verdict outside a final byte or with failure");

    a_verdict_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.message_done |-> o_out.failed != o_out.accepted)
        else $error("final byte verdict is ambiguous");

    a_restart_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && last |=> r_phase == PH_VERSION && r_offset == 8'd0 && !r_error_seen)
        else $error("parser did not restart after final byte");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_out.valid && o_out.echo_byte == $past(b))
        else $error("result missing after accepted request");

    a_excess_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && r_phase == PH_EXCESS |=> o_out.failed && !o_out.accepted)
        else $error("excess byte not flagged");

endmodule

// ===== tb/sv/arpc_echo_checker.sv =====
module arpc_echo_checker
    import arpc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    arpc_cfg_if  i_cfg,
    arpc_in_if   i_in,
    arpc_out_if  i_out,
    output int   o_failures,
    output int   o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [3:0] tag;
        logic [7:0] echo;
        logic [7:0] offset;
        logic       done;
        logic       failed;
        logic       accepted;
    } t_echo;

    logic [7:0]  symbol_max;
    logic [7:0]  name_max;
    logic [7:0]  custody_max;

    t_phase      parse_phase;
    logic [7:0]  field_pos;
    logic [7:0]  body_length;
    logic [1:0]  issuer_held;
    logic [1:0]  utf8_left;
    logic [20:0] utf8_value;
    logic [1:0]  utf8_class;
    logic        rule_broken;

    t_echo       pending_echoes[$];
    int          mismatch_count = 0;

    function automatic void restart_message();
        parse_phase = PH_VERSION;
        field_pos   = 8'd0;
        body_length = 8'd0;
        issuer_held = 2'd0;
        utf8_left   = 2'd0;
        utf8_value  = 21'd0;
        utf8_class  = 2'd0;
        rule_broken = 1'b0;
    endfunction

    function automatic void enter_field(input t_phase next);
        parse_phase = next;
        field_pos   = 8'd0;
    endfunction

    function automatic void advance_within(input logic [7:0] last_pos, input t_phase next);
        if (field_pos == last_pos) begin
            enter_field(next);
        end else begin
            field_pos = field_pos + 8'd1;
        end
    endfunction

    function automatic t_echo predict_echo(input logic [7:0] b, input logic last);
        t_echo       r;
        t_phase      tag;
        logic [7:0]  pos;
        logic [20:0] floor_code;
        logic        ok;
        tag = parse_phase;
        pos = field_pos;
        case (tag)
            PH_VERSION: begin
                if (b != pos) rule_broken = 1'b1;
                advance_within(VERSION_LAST, PH_ID);
            end
            PH_ID:   advance_within(HASH_LAST, PH_SALT);
            PH_SALT: advance_within(HASH_LAST, PH_SYMLEN);
            PH_SYMLEN: begin
                if (b == 8'd0 || b > symbol_max) rule_broken = 1'b1;
                body_length = b;
                enter_field(b == 8'd0 ? PH_NAMELEN : PH_SYMBOL);
            end
            PH_SYMBOL: begin
                if (b > ASCII_MAX) rule_broken = 1'b1;
                advance_within(body_length - 8'd1, PH_NAMELEN);
            end
            PH_NAMELEN: begin
                if (b == 8'd0 || b > name_max) rule_broken = 1'b1;
                body_length = b;
                utf8_left   = 2'd0;
                utf8_value  = 21'd0;
                utf8_class  = 2'd0;
                enter_field(b == 8'd0 ? PH_DECIMALS : PH_NAME);
            end
            PH_NAME: begin
                if (utf8_left == 2'd0) begin
                    if (b >= UTF8_LEAD2_MIN && b <= UTF8_LEAD2_MAX) begin
                        utf8_value = {16'd0, b[4:0]};
                        utf8_left  = 2'd1;
                        utf8_class = 2'd1;
                    end else if (b >= UTF8_LEAD3_MIN && b <= UTF8_LEAD3_MAX) begin
                        utf8_value = {17'd0, b[3:0]};
                        utf8_left  = 2'd2;
                        utf8_class = 2'd2;
                    end else if (b >= UTF8_LEAD4_MIN && b <= UTF8_LEAD4_MAX) begin
                        utf8_value = {18'd0, b[2:0]};
                        utf8_left  = 2'd3;
                        utf8_class = 2'd3;
                    end else if (b > ASCII_MAX) begin
                        rule_broken = 1'b1;
                    end
                end else if (b[7:6] != 2'b10) begin
                    rule_broken = 1'b1;
                    utf8_left   = 2'd0;
                end else begin
                    utf8_value = {utf8_value[14:0], b[5:0]};
                    utf8_left  = utf8_left - 2'd1;
                    if (utf8_left == 2'd0) begin
                        floor_code = utf8_class == 2'd3 ? UTF8_MIN_4 :
                                     utf8_class == 2'd2 ? UTF8_MIN_3 : UTF8_MIN_2;
                        if (utf8_value < floor_code || utf8_value > UTF8_MAX ||
                            (utf8_value >= UTF8_SURR_LO && utf8_value <= UTF8_SURR_HI))
                            rule_broken = 1'b1;
                    end
                end
                // A sequence may not stay open past the last name byte.
                if (field_pos == body_length - 8'd1 && utf8_left != 2'd0) begin
                    rule_broken = 1'b1;
                    utf8_left   = 2'd0;
                end
                advance_within(body_length - 8'd1, PH_DECIMALS);
            end
            PH_DECIMALS: begin
                if (b > DECIMALS_MAX) rule_broken = 1'b1;
                enter_field(PH_CAP);
            end
            PH_CAP: advance_within(CAP_LAST, PH_ISSUER);
            PH_ISSUER: begin
                if (b == ISSUER_SELF || b == ISSUER_CUSTODY) begin
                    issuer_held = b[1:0];
                end else begin
                    issuer_held = 2'd0;
                    rule_broken = 1'b1;
                end
                enter_field(PH_CUSTLEN);
            end
            PH_CUSTLEN: begin
                if (b > custody_max || ({6'd0, issuer_held} == ISSUER_SELF && b != 8'd0))
                    rule_broken = 1'b1;
                body_length = b;
                enter_field(b == 8'd0 ? PH_EXCESS : PH_CUSTODY);
            end
            PH_CUSTODY: advance_within(body_length - 8'd1, PH_EXCESS);
            default: begin
                rule_broken = 1'b1;
                if (field_pos < EXCESS_OFF_MAX) field_pos = field_pos + 8'd1;
            end
        endcase
        ok = last && !rule_broken && parse_phase == PH_EXCESS;
        r.tag      = tag;
        r.echo     = b;
        r.offset   = pos;
        r.done     = last;
        r.failed   = rule_broken || (last && !ok);
        r.accepted = ok;
        if (last) restart_message();
        return r;
    endfunction

    function automatic void check_field(input string field, input int want, input int got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_echo got;
        t_echo want;
        if (!i_rst_n) begin
            symbol_max  = LIMIT_RESET;
            name_max    = LIMIT_RESET;
            custody_max = LIMIT_RESET;
            restart_message();
            pending_echoes.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.addr)
                    CFG_SYMBOL_LIMIT:  symbol_max  = i_cfg.wdata;
                    CFG_NAME_LIMIT:    name_max    = i_cfg.wdata;
                    CFG_CUSTODY_LIMIT: custody_max = i_cfg.wdata;
                    default: ;
                endcase
            end
            if (i_out.valid && i_out.ready) begin
                got = '{i_out.field_tag, i_out.echo_byte, i_out.field_offset,
                        i_out.message_done, i_out.failed, i_out.accepted};
                if (pending_echoes.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result with no request waiting, expected none, actual %h",
                             $time, got);
                end else begin
                    want = pending_echoes.pop_front();
                    check_field("field_tag", want.tag, got.tag);
                    check_field("echo_byte", want.echo, got.echo);
                    check_field("field_offset", want.offset, got.offset);
                    check_field("message_done", want.done, got.done);
                    check_field("failed", want.failed, got.failed);
                    check_field("accepted", want.accepted, got.accepted);
                end
            end
            if (i_in.valid && i_in.ready)
                pending_echoes.push_back(predict_echo(i_in.data_byte, i_in.end_of_message));
        end
        o_outstanding <= pending_echoes.size();
        o_failures    <= mismatch_count;
    end

endmodule

// ===== tb/sv/asset_register_payload_checker_tb.sv =====
module asset_register_payload_checker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import arpc_pkg::*;

    localparam int                    CLK_PERIOD     = 10;
    localparam int                    RESET_CYCLES   = 7;
    localparam int                    PHASE_COUNT    = 5;
    localparam int                    PHASE_BYTES    = 200;
    localparam int                    LONG_HOLD      = 300;
    localparam int                    LONG_TAIL      = 258;
    localparam int                    PAUSE_AT_BYTE  = 40;
    localparam int                    DRAIN_CYCLES   = 8;
    localparam int                    WATCHDOG_LIMIT = 2000;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE      = 2'd3;

    localparam logic [7:0] EDGE_LEADS [8] = '{8'hc2, 8'hdf, 8'he0, 8'hed,
                                              8'hee, 8'hef, 8'hf0, 8'hf4};
    localparam logic [7:0] EDGE_SECONDS [6] = '{8'h80, 8'h8f, 8'h90, 8'h9f, 8'ha0, 8'hbf};

    logic i_clk = 1'b0;
    logic i_rst_n;

    arpc_cfg_if cfg_ch ();
    arpc_in_if  req_ch ();
    arpc_out_if rsp_ch ();

    int results_due;
    int failures;

    logic [7:0] msg_q[$];
    logic [7:0] lim_symbol  = LIMIT_RESET;
    logic [7:0] lim_name    = LIMIT_RESET;
    logic [7:0] lim_custody = LIMIT_RESET;
    int         burst_left  = 0;
    bit         offering    = 1'b0;
    bit         long_hold_armed = 1'b0;
    int         idle_cycles = 0;

    asset_register_payload_checker u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (req_ch),
        .o_out   (rsp_ch)
    );

    arpc_echo_checker u_echo_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg_ch),
        .i_in          (req_ch),
        .i_out         (rsp_ch),
        .o_failures    (failures),
        .o_outstanding (results_due)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic bit one_in(input int n);
        return $urandom_range(n - 1) == 0;
    endfunction

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] pick_length(input logic [7:0] limit, input bit clean);
        int unsigned pick;
        pick = clean ? $urandom_range(39, 3) : $urandom_range(39);
        if (pick == 0) return 8'd0;
        if (pick == 1) return any_byte();
        if (pick == 2 && limit != 8'hff) return 8'($urandom_range(255, int'(limit) + 1));
        if (pick == 3) return limit;
        if (limit == 8'd0) return 8'd0;
        return 8'($urandom_range(limit < 8'd6 ? int'(limit) : 6, 1));
    endfunction

    task automatic add_name_char(input bit clean, input int room);
        int unsigned kind;
        int          conts;
        logic [7:0]  lead;
        kind  = clean ? $urandom_range(6) : $urandom_range(9);
        conts = 0;
        case (kind)
            4: begin
                lead  = 8'($urandom_range(8'hdf, 8'hc2));
                conts = 1;
            end
            5: begin
                lead  = clean ? 8'($urandom_range(8'hec, 8'he1)) : 8'($urandom_range(8'hef, 8'he0));
                conts = 2;
            end
            6: begin
                lead  = clean ? 8'($urandom_range(8'hf3, 8'hf1)) : 8'($urandom_range(8'hf4, 8'hf0));
                conts = 3;
            end
            7: lead = one_in(2) ? 8'($urandom_range(8'hc1, 8'h80)) :
                                  8'($urandom_range(8'hff, 8'hf5));
            8: begin
                msg_q.push_back(8'($urandom_range(8'hdf, 8'hc2)));
                lead = one_in(2) ? 8'($urandom_range(8'h7f)) : 8'($urandom_range(8'hff, 8'hc0));
            end
            9: begin
                lead  = EDGE_LEADS[$urandom_range(7)];
                conts = lead < 8'he0 ? 1 : (lead < 8'hf0 ? 2 : 3);
            end
            default: lead = 8'($urandom_range(8'h7f));
        endcase
        if (clean && conts + 1 > room) begin
            lead  = 8'($urandom_range(8'h7f));
            conts = 0;
        end
        msg_q.push_back(lead);
        for (int i = 0; i < conts; i++) begin
            if (kind == 9)
                msg_q.push_back(i == 0 ? EDGE_SECONDS[$urandom_range(5)] :
                                         (one_in(2) ? 8'h80 : 8'hbf));
            else
                msg_q.push_back(8'($urandom_range(8'hbf, 8'h80)));
        end
    endtask

    // A negative tail lets the message take any shape, including noise and an early end.
    task automatic make_message(input int tail);
        logic [7:0] len;
        logic [7:0] issuer;
        int         base;
        int         cut;
        bit         clean;
        msg_q.delete();
        if (tail < 0 && one_in(12)) begin
            repeat ($urandom_range(40, 1)) msg_q.push_back(any_byte());
            return;
        end
        clean = one_in(2);
        msg_q.push_back(!clean && one_in(12) ? any_byte() : 8'd0);
        msg_q.push_back(!clean && one_in(12) ? any_byte() : 8'd1);
        repeat (64) msg_q.push_back(any_byte());
        len = pick_length(lim_symbol, clean);
        msg_q.push_back(len);
        repeat (len) msg_q.push_back(!clean && one_in(12) ? any_byte() : 8'($urandom_range(8'h7f)));
        len = pick_length(lim_name, clean);
        msg_q.push_back(len);
        base = msg_q.size();
        while (msg_q.size() - base < len) add_name_char(clean, len - (msg_q.size() - base));
        while (msg_q.size() - base > len) void'(msg_q.pop_back());
        msg_q.push_back(!clean && one_in(8) ? 8'($urandom_range(255, 39)) : 8'($urandom_range(38)));
        repeat (16) msg_q.push_back(any_byte());
        if (!clean && one_in(10)) issuer = any_byte();
        else issuer = one_in(2) ? ISSUER_SELF : ISSUER_CUSTODY;
        msg_q.push_back(issuer);
        if (issuer == ISSUER_SELF) len = !clean && one_in(8) ? pick_length(lim_custody, 0) : 8'd0;
        else if (one_in(4)) len = 8'd0;
        else len = pick_length(lim_custody, clean);
        msg_q.push_back(len);
        repeat (len) msg_q.push_back(any_byte());
        if (tail < 0) begin
            tail = !clean && one_in(6) ? $urandom_range(3, 1) : 0;
            if (!clean && one_in(6)) begin
                cut = $urandom_range(msg_q.size() - 1, 1);
                while (msg_q.size() > cut) void'(msg_q.pop_back());
            end
        end
        repeat (tail) msg_q.push_back(any_byte());
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        req_ch.valid          <= 1'b1;
        req_ch.data_byte      <= b;
        req_ch.end_of_message <= last;
        offering = 1'b1;
        do @(posedge i_clk); while (!req_ch.ready);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(40, 1);
            gap = one_in(3) ? 0 : $urandom_range(6, 1);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                offering = 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic stop_offering();
        if (offering) begin
            req_ch.valid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    task automatic wait_for_results();
        stop_offering();
        do @(posedge i_clk); while (results_due != 0);
    endtask

    task automatic send_message(input int pause_at);
        foreach (msg_q[i]) begin
            if (i == pause_at) wait_for_results();
            send_byte(msg_q[i], i == msg_q.size() - 1);
        end
    endtask

    task automatic program_limits(input logic [7:0] sym, input logic [7:0] name,
                                  input logic [7:0] cust);
        logic [CFG_ADDR_W-1:0] addrs [4];
        logic [7:0]            values [4];
        addrs  = '{CFG_SYMBOL_LIMIT, CFG_NAME_LIMIT, CFG_CUSTODY_LIMIT, CFG_SPARE};
        values = '{sym, name, cust, any_byte()};
        for (int k = 0; k < 4; k++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.addr  <= addrs[k];
            cfg_ch.wdata <= values[k];
            do @(posedge i_clk); while (!cfg_ch.ready);
        end
        cfg_ch.valid <= 1'b0;
        lim_symbol  = sym;
        lim_name    = name;
        lim_custody = cust;
    endtask

    initial begin
        int cyc;
        int mode;
        int hold_left;
        bit hold_done;
        logic rdy;
        cyc       = 0;
        mode      = 0;
        hold_left = 0;
        hold_done = 1'b0;
        rsp_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (long_hold_armed && !hold_done) begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (cyc % 128 == 0) mode = $urandom_range(4);
            if (hold_left > 0) begin
                rdy = 1'b0;
                hold_left--;
            end else begin
                case (mode)
                    0: rdy = 1'b1;
                    1: rdy = $urandom_range(3) != 0;
                    2: rdy = $urandom_range(1);
                    3: rdy = $urandom_range(3) == 0;
                    default: rdy = (cyc % 4) == 0;
                endcase
            end
            rsp_ch.ready <= rdy;
            @(posedge i_clk);
            cyc++;
        end
    end

    initial begin
        int phase_bytes;
        bit first;
        i_rst_n               <= 1'b0;
        req_ch.valid          <= 1'b0;
        req_ch.data_byte      <= 8'd0;
        req_ch.end_of_message <= 1'b0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.addr           <= CFG_SYMBOL_LIMIT;
        cfg_ch.wdata          <= 8'd0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Short requests that end the message early or break the version field.
        msg_q = '{8'h00};
        send_message(-1);
        msg_q = '{8'hff};
        send_message(-1);
        msg_q = '{8'h00, 8'h01};
        send_message(-1);
        msg_q = '{8'h01, 8'h00, 8'h80};
        send_message(-1);
        msg_q = '{8'h00, 8'h01, 8'h00, 8'hff, 8'h55, 8'haa};
        send_message(-1);

        for (int p = 0; p < PHASE_COUNT; p++) begin
            if (p > 0) begin
                wait_for_results();
                case (p)
                    1: program_limits(8'd1, 8'd1, 8'd0);
                    2: program_limits(8'd4, 8'd6, 8'd3);
                    3: program_limits(8'd255, 8'd255, 8'd255);
                    default: program_limits(8'($urandom_range(255, 1)),
                                            8'($urandom_range(255, 1)), any_byte());
                endcase
            end
            if (p == 3) long_hold_armed = 1'b1;
            first       = 1'b1;
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                make_message(p == 2 && first ? LONG_TAIL : (p == 1 && first ? 0 : -1));
                send_message(p == 1 && first ? PAUSE_AT_BYTE : -1);
                phase_bytes += msg_q.size();
                first = 1'b0;
            end
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failures == 0 && results_due == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
